### src/opp_pkg.sv
// opp_pkg: shared widths, command codes and controller states for the
// opcode pair profiler. No dependencies.
`timescale 1ns / 1ps

package opp_pkg;

  localparam int OP_FIELD_W = 8;
  localparam int DATA_W     = 64;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int MASK_REGS  = 4;
  localparam int MASK_SEL_W = 2;
  localparam int MASK_BIT_W = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_START     = 2'd0,
    CMD_STOP      = 2'd1,
    CMD_READ_OP   = 2'd2,
    CMD_READ_PAIR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_WRITE
  } state_t;

endpackage

### src/opp_in_if.sv
// opp_in_if: event channel (valid/ready plus event payload).
// Depends on opp_pkg for field widths.
`timescale 1ns / 1ps

interface opp_in_if import opp_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      cmd;
  logic [OP_FIELD_W-1:0] opcode;
  logic [OP_FIELD_W-1:0] pair_first;
  logic [DATA_W-1:0]     timestamp;

  modport source (output valid, cmd, opcode, pair_first, timestamp, input ready);
  modport sink   (input valid, cmd, opcode, pair_first, timestamp, output ready);
endinterface

### src/opp_out_if.sv
// opp_out_if: result channel (valid/ready plus counter payload).
// Depends on opp_pkg for field widths.
`timescale 1ns / 1ps

interface opp_out_if import opp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] op_count;
  logic [DATA_W-1:0] op_elapsed;
  logic [DATA_W-1:0] pair_count;
  logic              pair_recorded;

  modport source (output valid, op_count, op_elapsed, pair_count, pair_recorded,
                  input ready);
  modport sink   (input valid, op_count, op_elapsed, pair_count, pair_recorded,
                  output ready);
endinterface

### src/opp_cfg_if.sv
// opp_cfg_if: configuration write channel (valid/ready, index, data).
// Depends on opp_pkg for field widths.
`timescale 1ns / 1ps

interface opp_cfg_if import opp_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/opcode_pair_profiler.sv
// Each event passes the read, compute and write-back states on the counter
// memories before the next is taken; write-back stalls on an unaccepted result.
// Results sit in an output register, so the next event is taken while one waits.
// Reset: synchronous; a clearing pass over all 2^(2*clog2(OPCODE_COUNT)) pair
// addresses (65536 by default) zeroes all memories, events are held off meanwhile,
// configuration writes are taken throughout. Record masks reset to all ones.
// Depends on opp_pkg, opp_in_if, opp_out_if, opp_cfg_if.
`timescale 1ns / 1ps

module opcode_pair_profiler
  import opp_pkg::*;
#(
  parameter int OPCODE_COUNT = 256
) (
  input  logic       clk,
  input  logic       rst,
  opp_in_if.sink     evt,
  opp_out_if.source  res,
  opp_cfg_if.sink    cfg
);

  localparam int OP_W        = (OPCODE_COUNT > 1) ? $clog2(OPCODE_COUNT) : 1;
  localparam int SMALL_DEPTH = 1 << OP_W;
  localparam int PAIR_W      = 2 * OP_W;
  localparam int PAIR_DEPTH  = 1 << PAIR_W;

  // memories
  logic [DATA_W-1:0] stamp_mem   [SMALL_DEPTH];
  logic [DATA_W-1:0] count_mem   [SMALL_DEPTH];
  logic [DATA_W-1:0] elapsed_mem [SMALL_DEPTH];
  logic [DATA_W-1:0] pair_mem    [PAIR_DEPTH];

  logic [DATA_W-1:0] stamp_rd, count_rd, elapsed_rd, pair_rd;

  state_t state, state_next;

  logic [DATA_W-1:0]     record_mask [MASK_REGS];
  logic [PAIR_W-1:0]     clr_addr;
  logic [OP_FIELD_W-1:0] prev_op;

  // accepted item
  cmd_t                  cmd_q;
  logic [OP_FIELD_W-1:0] op_q;
  logic [DATA_W-1:0]     ts_q;
  logic                  op_ok_q;
  logic                  pair_ok_q;   // pair read with both members in range
  logic                  pair_rec_q;  // stop that bumps a pair counter

  // compute stage
  logic [DATA_W-1:0] delta, count_hold, elapsed_hold, pair_hold;

  // output register
  logic              out_valid;
  logic [DATA_W-1:0] out_count, out_elapsed, out_pair;
  logic              out_rec;

  // control
  logic evt_fire, rd_en, wr_fire, clr_done;

  // decode of the incoming event
  cmd_t              in_cmd;
  logic              in_op_ok, in_first_ok;
  logic [OP_W-1:0]   in_op_addr;
  logic [PAIR_W-1:0] in_pair_addr;

  // write-back values
  logic              do_stop, may_remember;
  logic [DATA_W-1:0] count_new, elapsed_new, pair_new;
  logic              stamp_we, op_we, pair_we;
  logic [OP_W-1:0]   small_waddr;
  logic [PAIR_W-1:0] pair_waddr;
  logic [DATA_W-1:0] stamp_wdata, count_wdata, elapsed_wdata, pair_wdata;

  assign cfg.ready = 1'b1;

  assign in_cmd      = cmd_t'(evt.cmd);
  assign in_op_ok    = 32'(evt.opcode) < OPCODE_COUNT;
  assign in_first_ok = 32'(evt.pair_first) < OPCODE_COUNT;
  assign in_op_addr  = evt.opcode[OP_W-1:0];
  // a stop bumps (previous, opcode); a pair read addresses (pair_first, opcode)
  assign in_pair_addr = (in_cmd == CMD_STOP) ? {prev_op[OP_W-1:0], in_op_addr}
                                             : {evt.pair_first[OP_W-1:0], in_op_addr};

  assign clr_done = (clr_addr == {PAIR_W{1'b1}});

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_done) state_next = ST_IDLE;
      ST_IDLE:  if (evt.valid) state_next = ST_CALC;
      ST_CALC:  state_next = ST_WRITE;
      ST_WRITE: if (!out_valid || res.ready) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    evt.ready = 1'b0;
    wr_fire   = 1'b0;
    case (state)
      ST_IDLE:  evt.ready = 1'b1;
      ST_WRITE: wr_fire   = !out_valid || res.ready;
      default: begin
        evt.ready = 1'b0;
        wr_fire   = 1'b0;
      end
    endcase
  end

  assign evt_fire = evt.valid && evt.ready;
  assign rd_en    = evt_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR && !clr_done) begin
      clr_addr <= clr_addr + PAIR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MASK_REGS; k++) record_mask[k] <= '1;
    end else if (cfg.valid && cfg.ready && cfg.index < CFG_IDX_W'(MASK_REGS)) begin
      record_mask[cfg.index[MASK_SEL_W-1:0]] <= cfg.data;
    end
  end

  // capture the event
  always_ff @(posedge clk) begin
    if (evt_fire) begin
      cmd_q      <= in_cmd;
      op_q       <= evt.opcode;
      ts_q       <= evt.timestamp;
      op_ok_q    <= in_op_ok;
      pair_ok_q  <= in_op_ok && in_first_ok;
      pair_rec_q <= (in_cmd == CMD_STOP) && in_op_ok && (prev_op != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CALC) begin
      delta        <= ts_q - stamp_rd;
      count_hold   <= count_rd;
      elapsed_hold <= elapsed_rd;
      pair_hold    <= pair_rd;
    end
  end

  assign do_stop      = (cmd_q == CMD_STOP) && op_ok_q;
  assign may_remember = record_mask[op_q[OP_FIELD_W-1 -: MASK_SEL_W]][op_q[MASK_BIT_W-1:0]];
  assign count_new    = count_hold + DATA_W'(1);
  assign elapsed_new  = elapsed_hold + delta;
  assign pair_new     = pair_hold + DATA_W'(1);

  // write ports: clearing pass or write-back
  always_comb begin
    if (state == ST_CLEAR) begin
      stamp_we      = 1'b1;
      op_we         = 1'b1;
      pair_we       = 1'b1;
      small_waddr   = clr_addr[OP_W-1:0];
      pair_waddr    = clr_addr;
      stamp_wdata   = '0;
      count_wdata   = '0;
      elapsed_wdata = '0;
      pair_wdata    = '0;
    end else begin
      stamp_we      = wr_fire && (cmd_q == CMD_START) && op_ok_q;
      op_we         = wr_fire && do_stop;
      pair_we       = wr_fire && pair_rec_q;
      small_waddr   = op_q[OP_W-1:0];
      pair_waddr    = {prev_op[OP_W-1:0], op_q[OP_W-1:0]};
      stamp_wdata   = ts_q;
      count_wdata   = count_new;
      elapsed_wdata = elapsed_new;
      pair_wdata    = pair_new;
    end
  end

  always_ff @(posedge clk) begin
    if (stamp_we) stamp_mem[small_waddr] <= stamp_wdata;
    if (rd_en) stamp_rd <= stamp_mem[in_op_addr];
  end

  always_ff @(posedge clk) begin
    if (op_we) count_mem[small_waddr] <= count_wdata;
    if (rd_en) count_rd <= count_mem[in_op_addr];
  end

  always_ff @(posedge clk) begin
    if (op_we) elapsed_mem[small_waddr] <= elapsed_wdata;
    if (rd_en) elapsed_rd <= elapsed_mem[in_op_addr];
  end

  always_ff @(posedge clk) begin
    if (pair_we) pair_mem[pair_waddr] <= pair_wdata;
    if (rd_en) pair_rd <= pair_mem[in_pair_addr];
  end

  // predecessor changes only at write-back, before the next event is read
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_op <= '0;
    end else if (wr_fire && do_stop) begin
      prev_op <= may_remember ? op_q : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wr_fire) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      out_count   <= '0;
      out_elapsed <= '0;
      out_pair    <= '0;
      out_rec     <= 1'b0;
      case (cmd_q)
        CMD_STOP: begin
          if (op_ok_q) begin
            out_count   <= count_new;
            out_elapsed <= elapsed_new;
            out_pair    <= pair_rec_q ? pair_new : '0;
            out_rec     <= pair_rec_q;
          end
        end
        CMD_READ_OP: begin
          if (op_ok_q) begin
            out_count   <= count_hold;
            out_elapsed <= elapsed_hold;
          end
        end
        CMD_READ_PAIR: begin
          if (pair_ok_q) out_pair <= pair_hold;
        end
        default: begin
          out_rec <= 1'b0;
        end
      endcase
    end
  end

  assign res.valid         = out_valid;
  assign res.op_count      = out_count;
  assign res.op_elapsed    = out_elapsed;
  assign res.pair_count    = out_pair;
  assign res.pair_recorded = out_rec;

endmodule

### tb/sv/opp_tally_checker.sv
// opp_tally_checker: watches the event, result and configuration channels of the
// opcode pair profiler, keeps its own copy of the counters and compares every result.
// Depends on opp_pkg, opp_in_if, opp_out_if and opp_cfg_if.
`timescale 1ns / 1ps

module opp_tally_checker
  import opp_pkg::*;
#(
  parameter int OPCODE_COUNT = 256
) (
  input  logic clk,
  input  logic rst,
  opp_in_if    evt,
  opp_out_if   res,
  opp_cfg_if   cfg,
  output int   errors,
  output int   pending,
  output int   checked,
  output int   pair_hits
);

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] elapsed;
    logic [DATA_W-1:0] pair;
    logic              recorded;
  } tally_t;

  logic [DATA_W-1:0] record_mask [MASK_REGS];
  logic [DATA_W-1:0] armed_at    [OPCODE_COUNT];
  logic [DATA_W-1:0] stop_count  [OPCODE_COUNT];
  logic [DATA_W-1:0] busy_time   [OPCODE_COUNT];
  logic [DATA_W-1:0] pair_tab    [int];
  int unsigned       last_op;
  tally_t            tally_q [$];

  function automatic logic [DATA_W-1:0] pair_value(int key);
    return pair_tab.exists(key) ? pair_tab[key] : '0;
  endfunction

  // Applies one event to the shadow counters and returns the result it should produce.
  function automatic tally_t profile_event(cmd_t c, int unsigned op, int unsigned first,
                                           logic [DATA_W-1:0] stamp);
    tally_t t;
    int     key;
    t = '0;
    case (c)
      CMD_START: begin
        if (op < OPCODE_COUNT) armed_at[op] = stamp;
      end
      CMD_STOP: begin
        if (op < OPCODE_COUNT) begin
          busy_time[op]  = busy_time[op] + (stamp - armed_at[op]);
          stop_count[op] = stop_count[op] + DATA_W'(1);
          t.count   = stop_count[op];
          t.elapsed = busy_time[op];
          if (last_op != 0 && last_op < OPCODE_COUNT) begin
            key = last_op * OPCODE_COUNT + op;
            pair_tab[key] = pair_value(key) + DATA_W'(1);
            t.pair     = pair_tab[key];
            t.recorded = 1'b1;
          end
          // opcode 0 doubles as "no predecessor"
          last_op = record_mask[op[7:6]][op[5:0]] ? op : 0;
        end
      end
      CMD_READ_OP: begin
        if (op < OPCODE_COUNT) begin
          t.count   = stop_count[op];
          t.elapsed = busy_time[op];
        end
      end
      default: begin
        if (op < OPCODE_COUNT && first < OPCODE_COUNT)
          t.pair = pair_value(first * OPCODE_COUNT + op);
      end
    endcase
    return t;
  endfunction

  always @(posedge clk) begin
    tally_t got;
    tally_t want;
    if (rst) begin
      for (int i = 0; i < MASK_REGS; i++) record_mask[i] = '1;
      for (int i = 0; i < OPCODE_COUNT; i++) begin
        armed_at[i]   = '0;
        stop_count[i] = '0;
        busy_time[i]  = '0;
      end
      pair_tab.delete();
      tally_q.delete();
      last_op   = 0;
      errors    = 0;
      pending   = 0;
      checked   = 0;
      pair_hits = 0;
    end else begin
      if (cfg.valid && cfg.ready && cfg.index < MASK_REGS)
        record_mask[cfg.index[MASK_SEL_W-1:0]] = cfg.data;

      if (res.valid && res.ready) begin
        got.count    = res.op_count;
        got.elapsed  = res.op_elapsed;
        got.pair     = res.pair_count;
        got.recorded = res.pair_recorded;
        if (tally_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("checker: %0t: result with nothing expected: count %h elapsed %h",
                     $time, got.count, got.elapsed, " pair %h recorded %b",
                     got.pair, got.recorded);
        end else begin
          want = tally_q.pop_front();
          pending--;
          checked++;
          if (got.count !== want.count || got.elapsed !== want.elapsed ||
              got.pair !== want.pair || got.recorded !== want.recorded) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("checker: %0t: mismatch (expected/actual) count %h/%h", $time,
                       want.count, got.count, " elapsed %h/%h", want.elapsed, got.elapsed,
                       " pair %h/%h", want.pair, got.pair,
                       " recorded %b/%b", want.recorded, got.recorded);
          end
        end
      end

      // a result is registered only at write-back, so it never belongs to this edge's transaction
      if (evt.valid && evt.ready) begin
        want = profile_event(cmd_t'(evt.cmd), 32'(evt.opcode), 32'(evt.pair_first),
                             evt.timestamp);
        tally_q.push_back(want);
        pending++;
        if (want.recorded) pair_hits++;
      end
    end
  end

endmodule

### tb/sv/testbench.sv
// testbench: drives start/stop/read events and mask writes into the opcode pair
// profiler with random idling on both sides. Depends on opp_pkg, the channel
// interfaces, opcode_pair_profiler and opp_tally_checker.
`timescale 1ns / 1ps

module testbench;
  import opp_pkg::*;

  localparam int OPCODES      = 256;
  localparam int GAP_MAX      = 19;
  localparam int POOL_SIZE    = 6;
  localparam int HOLD_EVERY   = 120;
  localparam int DRAIN_CYCLES = 10;
  localparam int STRAY_REG    = 255;  // index past the mask registers, must be ignored

  logic clk;
  logic rst;

  opp_in_if  evt_if ();
  opp_out_if res_if ();
  opp_cfg_if cfg_if ();

  int errors;
  int pending;
  int checked;
  int pair_hits;

  bit                calm;
  int                sent;
  logic [DATA_W-1:0] now;
  logic [7:0]        op_pool [POOL_SIZE];

  opcode_pair_profiler #(.OPCODE_COUNT(OPCODES)) u_top (
    .clk (clk),
    .rst (rst),
    .evt (evt_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  opp_tally_checker #(.OPCODE_COUNT(OPCODES)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt_if),
    .res       (res_if),
    .cfg       (cfg_if),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .pair_hits (pair_hits)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [DATA_W-1:0] tick();
    now = now + DATA_W'($urandom_range(1, 300));
    return now;
  endfunction

  function automatic logic [DATA_W-1:0] span();
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    return DATA_W'($urandom_range(0, 400));
  endfunction

  // mostly a few hot opcodes so pair counters climb
  function automatic logic [7:0] pick_op();
    if ($urandom_range(0, 4) != 0) return op_pool[$urandom_range(0, POOL_SIZE - 1)];
    return 8'($urandom_range(0, OPCODES - 1));
  endfunction

  task automatic send_event(input cmd_t c, input logic [7:0] op, input logic [7:0] first,
                            input logic [DATA_W-1:0] stamp);
    int gap;
    gap = calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      evt_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    evt_if.valid      <= 1'b1;
    evt_if.cmd        <= c;
    evt_if.opcode     <= op;
    evt_if.pair_first <= first;
    evt_if.timestamp  <= stamp;
    @(posedge clk);
    while (!evt_if.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    evt_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic program_masks(input logic [DATA_W-1:0] m0, input logic [DATA_W-1:0] m1,
                               input logic [DATA_W-1:0] m2, input logic [DATA_W-1:0] m3,
                               input bit stray);
    logic [DATA_W-1:0] vals [MASK_REGS + 1];
    int                n;
    vals[0] = m0;
    vals[1] = m1;
    vals[2] = m2;
    vals[3] = m3;
    vals[4] = {$urandom, $urandom};
    n = stray ? MASK_REGS + 1 : MASK_REGS;
    for (int i = 0; i < n; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= (i < MASK_REGS) ? CFG_IDX_W'(i) : CFG_IDX_W'(STRAY_REG);
      cfg_if.data  <= vals[i];
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_directed();
    send_event(CMD_READ_OP,   8'd0,   8'd0,   '0);
    send_event(CMD_READ_PAIR, 8'd255, 8'd255, '1);
    send_event(CMD_START,     8'd0,   8'd0,   64'd0);
    send_event(CMD_STOP,      8'd0,   8'd0,   64'd5);
    send_event(CMD_START,     8'd255, 8'd0,   64'hFFFF_FFFF_FFFF_FFF0);
    send_event(CMD_STOP,      8'd255, 8'd0,   64'h10);                  // time wraps
    send_event(CMD_START,     8'd1,   8'd0,   64'd100);
    send_event(CMD_STOP,      8'd1,   8'd0,   64'd90);                  // negative span
    send_event(CMD_STOP,      8'd1,   8'd0,   '1);                      // stop without start
    send_event(CMD_STOP,      8'd0,   8'd0,   64'd7);                   // opcode 0 clears pred
    send_event(CMD_STOP,      8'd128, 8'd0,   64'd42);
    send_event(CMD_STOP,      8'd255, 8'd0,   64'h8000_0000_0000_0000);
    send_event(CMD_READ_OP,   8'd255, 8'hAA,  '0);
    send_event(CMD_READ_OP,   8'd1,   8'd0,   '0);
    send_event(CMD_READ_OP,   8'd0,   8'd0,   '0);
    send_event(CMD_READ_PAIR, 8'd1,   8'd255, '0);
    send_event(CMD_READ_PAIR, 8'd1,   8'd1,   '0);
    send_event(CMD_READ_PAIR, 8'd0,   8'd1,   '0);
    send_event(CMD_READ_PAIR, 8'd1,   8'd0,   '0);
    send_event(CMD_READ_PAIR, 8'd255, 8'd128, '0);
    send_event(CMD_START,     8'd255, 8'h55,  64'h5555_5555_5555_5555);
    send_event(CMD_STOP,      8'd255, 8'hAA,  64'hAAAA_AAAA_AAAA_AAAA);
    send_event(CMD_READ_PAIR, 8'd255, 8'd255, '0);
  endtask

  task automatic random_phase(input int count, input logic [DATA_W-1:0] t_start);
    int                done_items;
    int                hold_at;
    int                r;
    logic [7:0]        a;
    logic [7:0]        b;
    logic [DATA_W-1:0] t0;
    now        = t_start;
    op_pool[0] = 8'd0;
    op_pool[1] = 8'd255;
    for (int i = 2; i < POOL_SIZE; i++) op_pool[i] = 8'($urandom_range(1, OPCODES - 2));
    done_items = 0;
    hold_at    = HOLD_EVERY;
    while (done_items < count) begin
      calm = (done_items % 100) < 20;
      if (done_items >= hold_at) begin
        drain();
        hold_at += HOLD_EVERY;
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
        a  = pick_op();
        t0 = tick();
        send_event(CMD_START, a, 8'($urandom_range(0, 255)), t0);
        send_event(CMD_STOP,  a, 8'($urandom_range(0, 255)), t0 + span());
        done_items += 2;
      end else if (r < 55) begin
        // nested: outer opcode spans the inner one
        a = pick_op();
        b = pick_op();
        send_event(CMD_START, a, 8'($urandom_range(0, 255)), tick());
        send_event(CMD_START, b, 8'($urandom_range(0, 255)), tick());
        send_event(CMD_STOP,  b, 8'($urandom_range(0, 255)), tick());
        send_event(CMD_STOP,  a, 8'($urandom_range(0, 255)), tick());
        done_items += 4;
      end else if (r < 68) begin
        send_event(CMD_READ_OP, pick_op(), 8'($urandom_range(0, 255)),
                   {$urandom, $urandom});
        done_items++;
      end else if (r < 81) begin
        send_event(CMD_READ_PAIR, pick_op(), pick_op(), {$urandom, $urandom});
        done_items++;
      end else if (r < 88) begin
        send_event(CMD_STOP, pick_op(), 8'($urandom_range(0, 255)), tick());
        done_items++;
      end else begin
        send_event(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), {$urandom, $urandom});
        done_items++;
      end
    end
    calm = 1'b0;
    drain();
  endtask

  // result side: random stall before each transaction
  initial begin
    int stall;
    res_if.ready = 1'b0;
    @(negedge clk);
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    rst               = 1'b1;
    evt_if.valid      = 1'b0;
    evt_if.cmd        = CMD_START;
    evt_if.opcode     = '0;
    evt_if.pair_first = '0;
    evt_if.timestamp  = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    calm              = 1'b0;
    sent              = 0;
    now               = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset masks first, then each setting once the pipeline is empty
    run_directed();
    drain();
    program_masks('0, '0, '0, '0, 1'b0);
    random_phase(150, 64'hFFFF_FFFF_FFFF_F000);
    program_masks({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, 1'b1);
    random_phase(250, {$urandom, $urandom});
    program_masks(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                  64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    random_phase(200, 64'd0);
    program_masks('1, '1, '1, '1, 1'b0);
    random_phase(200, {$urandom, $urandom});

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("summary: %0d events, %0d results compared, %0d pair increments", sent,
             checked, pair_hits);
    $display("summary: masks at reset, all clear, random with stray index, alternating, all set");
    if (errors == 0 && pending == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  // covers the post-reset clearing pass plus worst-case idling, several times over
  initial begin
    #6_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
